// File: sv/slt_pkg.sv
// Shared types, constants and helper functions for the stack-language tokenizer.
// No dependencies; the datapath, controller and top import this package.
package slt_pkg;

  // Name buffer sizing
  localparam int NAME_CAPACITY = 32;
  localparam int LEN_W         = $clog2(NAME_CAPACITY + 1);
  localparam int IDX_W         = $clog2(NAME_CAPACITY);

  // Number accumulator: 31 bits, product acc*10+9 fits in four more
  localparam int VAL_W = 31;
  localparam int MAC_W = VAL_W + 4;
  localparam logic [VAL_W-1:0] NUM_MAX = '1;

  // Character codes
  localparam logic [7:0] CHR_ZERO    = 8'h30;
  localparam logic [7:0] CHR_NINE    = 8'h39;
  localparam logic [7:0] CHR_UPPER_A = 8'h41;
  localparam logic [7:0] CHR_LOWER_Z = 8'h7A;
  localparam logic [7:0] CHR_SLASH   = 8'h2F;
  localparam logic [7:0] CHR_OPEN    = 8'h7B;
  localparam logic [7:0] CHR_CLOSE   = 8'h7D;
  localparam logic [7:0] CHR_SPACE   = 8'h20;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_NUM,
    MODE_EXEC,
    MODE_LIT
  } mode_e;

  typedef enum logic [2:0] {
    KIND_NUMBER,
    KIND_SPACE,
    KIND_EXEC,
    KIND_LIT,
    KIND_OPEN,
    KIND_CLOSE,
    KIND_END,
    KIND_UNKNOWN
  } kind_e;

  // Input character classes; end of input counts as a delimiter
  typedef enum logic [1:0] {
    CLS_DIGIT,
    CLS_LETTER,
    CLS_SLASH,
    CLS_DELIM
  } char_class_e;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_NAME,
    ST_TAIL
  } state_e;

  // Scanner state updates
  typedef enum logic [2:0] {
    UPD_NONE,
    UPD_DIGIT,
    UPD_APPEND,
    UPD_START_EXEC,
    UPD_START_LIT,
    UPD_CLEAR
  } upd_e;

  // Source of the result loaded into the output register
  typedef enum logic [2:0] {
    EMIT_NONE,
    EMIT_NUMBER,
    EMIT_NAME,
    EMIT_TOKEN_IN,
    EMIT_TOKEN_SAVED
  } emit_e;

  typedef struct packed {
    upd_e  upd;
    emit_e emit;
    logic  save_tail;
    logic  name_start;
    logic  name_step;
  } slt_cmd_t;

  typedef struct packed {
    mode_e       mode;
    char_class_e cls;
    logic        slot_free;
    logic        name_last;
    logic        tail_slash;
  } slt_stat_t;

  function automatic char_class_e classify(input logic [7:0] c, input logic eoi);
    char_class_e cls;
    if (eoi) begin
      cls = CLS_DELIM;
    end else if (c inside {[CHR_ZERO:CHR_NINE]}) begin
      cls = CLS_DIGIT;
    end else if (c inside {[CHR_UPPER_A:CHR_LOWER_Z]}) begin
      cls = CLS_LETTER;
    end else if (c == CHR_SLASH) begin
      cls = CLS_SLASH;
    end else begin
      cls = CLS_DELIM;
    end
    return cls;
  endfunction

  // Kind of a one-character token, or the end token
  function automatic kind_e token_kind(input logic [7:0] c, input logic eoi);
    kind_e k;
    if (eoi) begin
      k = KIND_END;
    end else begin
      case (c)
        CHR_SPACE: k = KIND_SPACE;
        CHR_OPEN:  k = KIND_OPEN;
        CHR_CLOSE: k = KIND_CLOSE;
        default:   k = KIND_UNKNOWN;
      endcase
    end
    return k;
  endfunction

endpackage

// File: sv/slt_in_if.sv
// Character input channel of the tokenizer: valid/ready plus one character and an end-of-input flag.
// Depends on nothing.
interface slt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_char;
  logic       end_of_input;

  modport source (output valid, output in_char, output end_of_input, input ready);
  modport sink   (input valid, input in_char, input end_of_input, output ready);
endinterface

// File: sv/slt_out_if.sv
// Token result channel of the tokenizer: valid/ready plus one result item.
// Depends on nothing.
interface slt_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  token_kind;
  logic [30:0] number_value;
  logic [7:0]  out_char;
  logic        last_of_token;
  logic        overflowed;

  modport source (output valid, output token_kind, output number_value, output out_char,
                  output last_of_token, output overflowed, input ready);
  modport sink   (input valid, input token_kind, input number_value, input out_char,
                  input last_of_token, input overflowed, output ready);
endinterface

// File: sv/slt_datapath.sv
// Tokenizer datapath: scan state, number accumulator, name memory, output register.
// Depends on slt_pkg; driven by slt_ctrl through slt_cmd_t.
module slt_datapath (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [7:0]       in_char_i,
  input  logic             end_of_input_i,
  input  slt_pkg::slt_cmd_t  cmd_i,
  output slt_pkg::slt_stat_t stat_o,
  input  logic             out_ready_i,
  output logic             out_valid_o,
  output logic [2:0]       token_kind_o,
  output logic [30:0]      number_value_o,
  output logic [7:0]       out_char_o,
  output logic             last_of_token_o,
  output logic             overflowed_o
);
  import slt_pkg::*;

  mode_e             mode_q, mode_d;
  logic [VAL_W-1:0]  acc_q, acc_d;
  logic [LEN_W-1:0]  len_q, len_d;
  logic              ovf_q, ovf_d;
  logic [IDX_W-1:0]  ptr_q, ptr_d;
  logic [7:0]        tail_char_q, tail_char_d;
  logic              tail_eoi_q, tail_eoi_d;
  logic [7:0]        name_mem [NAME_CAPACITY];
  logic [7:0]        rdata_q;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic [3:0]        digit;
  logic [MAC_W-1:0]  mac;
  logic              name_last;
  logic              slot_free;

  logic              out_valid_q, out_valid_d;
  logic [2:0]        kind_q, kind_d;
  logic [VAL_W-1:0]  val_q, val_d;
  logic [7:0]        char_q, char_d;
  logic              last_q, last_d;
  logic              oflw_q, oflw_d;

  // acc*10 + digit as shift-and-add
  assign digit = 4'(in_char_i - CHR_ZERO);
  assign mac   = (MAC_W'(acc_q) << 3) + (MAC_W'(acc_q) << 1) + MAC_W'(digit);

  assign name_last = (len_q == '0) || ((LEN_W'(ptr_q) + LEN_W'(1)) == len_q);
  assign slot_free = !out_valid_q || out_ready_i;

  // Scan state update
  always_comb begin
    mode_d  = mode_q;
    acc_d   = acc_q;
    len_d   = len_q;
    ovf_d   = ovf_q;
    wr_en   = 1'b0;
    wr_addr = len_q[IDX_W-1:0];
    case (cmd_i.upd)
      UPD_DIGIT: begin
        case (mode_q)
          MODE_NUM: begin
            if (mac > MAC_W'(NUM_MAX)) begin
              acc_d = NUM_MAX;
              ovf_d = 1'b1;
            end else begin
              acc_d = mac[VAL_W-1:0];
            end
          end
          MODE_EXEC, MODE_LIT: begin
            if (len_q < LEN_W'(NAME_CAPACITY)) begin
              wr_en = 1'b1;
              len_d = len_q + LEN_W'(1);
            end else begin
              ovf_d = 1'b1;
            end
          end
          default: begin
            mode_d = MODE_NUM;
            acc_d  = VAL_W'(digit);
            ovf_d  = 1'b0;
          end
        endcase
      end
      UPD_APPEND: begin
        if (len_q < LEN_W'(NAME_CAPACITY)) begin
          wr_en = 1'b1;
          len_d = len_q + LEN_W'(1);
        end else begin
          ovf_d = 1'b1;
        end
      end
      UPD_START_EXEC: begin
        mode_d  = MODE_EXEC;
        acc_d   = '0;
        ovf_d   = 1'b0;
        len_d   = LEN_W'(1);
        wr_en   = 1'b1;
        wr_addr = '0;
      end
      UPD_START_LIT: begin
        mode_d = MODE_LIT;
        acc_d  = '0;
        len_d  = '0;
        ovf_d  = 1'b0;
      end
      UPD_CLEAR: begin
        mode_d = MODE_IDLE;
        acc_d  = '0;
        len_d  = '0;
        ovf_d  = 1'b0;
      end
      default: ;
    endcase
  end

  // Read pointer and saved delimiter
  always_comb begin
    ptr_d = ptr_q;
    if (cmd_i.name_start) begin
      ptr_d = '0;
    end else if (cmd_i.name_step && !name_last) begin
      ptr_d = ptr_q + IDX_W'(1);
    end
    tail_char_d = tail_char_q;
    tail_eoi_d  = tail_eoi_q;
    if (cmd_i.save_tail) begin
      tail_char_d = in_char_i;
      tail_eoi_d  = end_of_input_i;
    end
  end

  // Output register load
  always_comb begin
    out_valid_d = out_valid_q;
    kind_d      = kind_q;
    val_d       = val_q;
    char_d      = char_q;
    last_d      = last_q;
    oflw_d      = oflw_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (cmd_i.emit)
      EMIT_NUMBER: begin
        out_valid_d = 1'b1;
        kind_d      = KIND_NUMBER;
        val_d       = acc_q;
        char_d      = '0;
        last_d      = 1'b1;
        oflw_d      = ovf_q;
      end
      EMIT_NAME: begin
        out_valid_d = 1'b1;
        kind_d      = (mode_q == MODE_EXEC) ? KIND_EXEC : KIND_LIT;
        val_d       = '0;
        char_d      = (len_q == '0) ? 8'h00 : rdata_q;
        last_d      = name_last;
        oflw_d      = ovf_q;
      end
      EMIT_TOKEN_IN: begin
        out_valid_d = 1'b1;
        kind_d      = token_kind(in_char_i, end_of_input_i);
        val_d       = '0;
        char_d      = end_of_input_i ? 8'h00 : in_char_i;
        last_d      = 1'b1;
        oflw_d      = 1'b0;
      end
      EMIT_TOKEN_SAVED: begin
        out_valid_d = 1'b1;
        kind_d      = token_kind(tail_char_q, tail_eoi_q);
        val_d       = '0;
        char_d      = tail_eoi_q ? 8'h00 : tail_char_q;
        last_d      = 1'b1;
        oflw_d      = 1'b0;
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_IDLE;
      acc_q       <= '0;
      len_q       <= '0;
      ovf_q       <= 1'b0;
      ptr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      mode_q      <= mode_d;
      acc_q       <= acc_d;
      len_q       <= len_d;
      ovf_q       <= ovf_d;
      ptr_q       <= ptr_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    tail_char_q <= tail_char_d;
    tail_eoi_q  <= tail_eoi_d;
    kind_q      <= kind_d;
    val_q       <= val_d;
    char_q      <= char_d;
    last_q      <= last_d;
    oflw_q      <= oflw_d;
  end

  // Name memory: one write port, registered read at the next pointer
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      name_mem[wr_addr] <= in_char_i;
    end
    rdata_q <= name_mem[ptr_d];
  end

  assign stat_o.mode       = mode_q;
  assign stat_o.cls        = classify(in_char_i, end_of_input_i);
  assign stat_o.slot_free  = slot_free;
  assign stat_o.name_last  = name_last;
  assign stat_o.tail_slash = !tail_eoi_q && (tail_char_q == CHR_SLASH);

  assign out_valid_o     = out_valid_q;
  assign token_kind_o    = kind_q;
  assign number_value_o  = val_q;
  assign out_char_o      = char_q;
  assign last_of_token_o = last_q;
  assign overflowed_o    = oflw_q;

endmodule

// File: sv/slt_ctrl.sv
// Tokenizer controller: accepts characters and sequences name flushes.
// Depends on slt_pkg; commands slt_datapath through slt_cmd_t.
module slt_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  slt_pkg::slt_stat_t stat_i,
  output slt_pkg::slt_cmd_t  cmd_o
);
  import slt_pkg::*;

  state_e state_q, state_d;
  logic   take;

  assign in_ready_o = (state_q == ST_RUN) && stat_i.slot_free;
  assign take       = in_valid_i && in_ready_o;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_RUN: begin
        if (take) begin
          if (stat_i.cls == CLS_SLASH && stat_i.mode == MODE_EXEC) begin
            state_d = ST_NAME;
          end else if (stat_i.cls == CLS_DELIM) begin
            case (stat_i.mode)
              MODE_NUM:            state_d = ST_TAIL;
              MODE_EXEC, MODE_LIT: state_d = ST_NAME;
              default:             state_d = ST_RUN;
            endcase
          end
        end
      end
      ST_NAME: begin
        if (stat_i.slot_free && stat_i.name_last) begin
          state_d = stat_i.tail_slash ? ST_RUN : ST_TAIL;
        end
      end
      ST_TAIL: begin
        if (stat_i.slot_free) begin
          state_d = ST_RUN;
        end
      end
      default: state_d = ST_RUN;
    endcase
  end

  // Datapath commands
  always_comb begin
    cmd_o = '{upd: UPD_NONE, emit: EMIT_NONE, save_tail: 1'b0,
              name_start: 1'b0, name_step: 1'b0};
    case (state_q)
      ST_RUN: begin
        if (take) begin
          case (stat_i.cls)
            CLS_DIGIT: cmd_o.upd = UPD_DIGIT;
            CLS_LETTER: begin
              case (stat_i.mode)
                MODE_EXEC, MODE_LIT: cmd_o.upd = UPD_APPEND;
                MODE_NUM: begin
                  cmd_o.emit = EMIT_NUMBER;
                  cmd_o.upd  = UPD_START_EXEC;
                end
                default: cmd_o.upd = UPD_START_EXEC;
              endcase
            end
            CLS_SLASH: begin
              case (stat_i.mode)
                MODE_LIT: ;
                MODE_NUM: begin
                  cmd_o.emit = EMIT_NUMBER;
                  cmd_o.upd  = UPD_START_LIT;
                end
                MODE_EXEC: begin
                  cmd_o.save_tail  = 1'b1;
                  cmd_o.name_start = 1'b1;
                end
                default: cmd_o.upd = UPD_START_LIT;
              endcase
            end
            default: begin
              case (stat_i.mode)
                MODE_NUM: begin
                  cmd_o.emit      = EMIT_NUMBER;
                  cmd_o.upd       = UPD_CLEAR;
                  cmd_o.save_tail = 1'b1;
                end
                MODE_EXEC, MODE_LIT: begin
                  cmd_o.save_tail  = 1'b1;
                  cmd_o.name_start = 1'b1;
                end
                default: cmd_o.emit = EMIT_TOKEN_IN;
              endcase
            end
          endcase
        end
      end
      ST_NAME: begin
        if (stat_i.slot_free) begin
          cmd_o.emit      = EMIT_NAME;
          cmd_o.name_step = 1'b1;
          if (stat_i.name_last) begin
            cmd_o.upd = stat_i.tail_slash ? UPD_START_LIT : UPD_CLEAR;
          end
        end
      end
      ST_TAIL: begin
        if (stat_i.slot_free) begin
          cmd_o.emit = EMIT_TOKEN_SAVED;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_RUN;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: sv/stack_language_tokenizer_top.sv
// Stack-language tokenizer: one character in per transaction, token items out.
// Character channel in_s (slt_in_if): in_char, end_of_input.
// Result channel out_s (slt_out_if): token_kind, number_value, out_char,
//   last_of_token, overflowed; a name leaves as one item per character.
// A character is taken while the scanner runs and the output register is free; one
//   that ends a number or is a one-character token from idle has its result
//   loaded into the output register, visible there on the next cycle.
// A delimiter ending a number gives two items, the number then the delimiter
//   token; one ending a name of N buffered characters gives N items (one if
//   empty) plus the delimiter token, with the character channel held off
//   meanwhile; a slash ending an exec name gives its N items and no delimiter token.
// Throughput: one character per cycle while the receiver takes each item, except
//   when a delimiter ends a number or a name is flushed, set by the single output
//   register and the one read port of the name memory.
// End of input flushes the pending token and then sends an end token.
// Reset: scanner idle, no pending token, output register empty.
// When the receiver stalls, the output register holds its item and the
//   character channel drops ready until the register can be reloaded.
// Depends on slt_pkg, slt_in_if, slt_out_if, slt_ctrl, slt_datapath.
module stack_language_tokenizer_top (
  input  logic           clk_i,
  input  logic           rst_ni,
  slt_in_if.sink         in_s,
  slt_out_if.source      out_s
);
  import slt_pkg::*;

  slt_cmd_t  cmd;
  slt_stat_t stat;

  slt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_s.valid),
    .in_ready_o (in_s.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  slt_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_char_i       (in_s.in_char),
    .end_of_input_i  (in_s.end_of_input),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .out_ready_i     (out_s.ready),
    .out_valid_o     (out_s.valid),
    .token_kind_o    (out_s.token_kind),
    .number_value_o  (out_s.number_value),
    .out_char_o      (out_s.out_char),
    .last_of_token_o (out_s.last_of_token),
    .overflowed_o    (out_s.overflowed)
  );

`ifndef SYNTHESIS
  // Never load the output register while it still holds an untaken item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.emit != EMIT_NONE) |-> stat.slot_free)
    else $error("result loaded over a pending item");

  // A digit never produces a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_s.valid && in_s.ready && stat.cls == CLS_DIGIT) |-> (cmd.emit == EMIT_NONE))
    else $error("digit produced a result");

  // End of input with nothing pending gives the end token next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_s.valid && in_s.ready && in_s.end_of_input && stat.mode == MODE_IDLE)
      |=> (out_s.valid && out_s.token_kind == KIND_END && out_s.last_of_token))
    else $error("end token missing");
`endif

endmodule
